// File: design/psalt_pkg.sv
// Package for the per-source authentication lockout table.
// Holds widths, operation codes, register map, beat structs and controller/datapath links.
// No dependencies.
package psalt_pkg;

	// Slot count; must stay a power of two (eviction slot is the low address bits).
	localparam int SLOTS  = 16;
	localparam int IDX_W  = $clog2(SLOTS);
	localparam int KEY_W  = 32;
	localparam int CNT_W  = 8;
	localparam int TIME_W = 48;
	localparam int DUR_W  = 32;
	localparam int PADDR_W = 3;

	localparam logic [1:0] FUNC_CHECK = 2'd0;
	localparam logic [1:0] FUNC_FAIL  = 2'd1;
	localparam logic [1:0] FUNC_OK    = 2'd2;

	localparam logic REG_LIMIT = 1'b0;
	localparam logic REG_DUR   = 1'b1;

	localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(8);
	localparam logic [DUR_W-1:0] DUR_RST   = DUR_W'(30000);

	typedef struct packed {
		logic [1:0]        func;
		logic [KEY_W-1:0]  peer_address;
		logic [TIME_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic              locked;
		logic [TIME_W-1:0] lock_remaining_ms;
	} result_t;

	typedef struct packed {
		logic load;
		logic step;
		logic resolve;
		logic exec;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_end;
	} dp_sts_t;

endpackage

// File: design/per_source_auth_lockout_table.sv
// Top level of the per-source authentication lockout table: APB registers,
// controller and datapath. Depends on psalt_pkg, psalt_ctrl, psalt_dp.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+----------------------------
//  item     | start & !busy                  | item (func, peer_address, now_ms)
//  result   | done, one cycle, no stall      | result (locked, lock_remaining_ms)
//  config   | psel & penable & pwrite, APB   | pwdata, paddr 0 limit, 4 lockout
//
// An item goes from acceptance to the done beat through a scan, one compare per
// cycle over the slot keys (stops at a match or at the last slot), a resolve
// step that picks the slot and an execute step that updates it. busy drops with
// done, so the next item may start in the done cycle. After reset the table is
// empty and usable at once. The receiver cannot stall; done lasts one cycle.
module per_source_auth_lockout_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  psalt_pkg::item_t                item,
	output logic                            done,
	output psalt_pkg::result_t              result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [psalt_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import psalt_pkg::*;

	logic [CNT_W-1:0] limit_q;
	logic [DUR_W-1:0] dur_q;
	dp_cmd_t          cmd;
	dp_sts_t          sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
			dur_q   <= DUR_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_LIMIT: limit_q <= pwdata[CNT_W-1:0];
				REG_DUR:   dur_q   <= pwdata[DUR_W-1:0];
				default:   limit_q <= limit_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_LIMIT: prdata = 32'(limit_q);
			REG_DUR:   prdata = 32'(dur_q);
			default:   prdata = '0;
		endcase
	end

	psalt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	psalt_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.item                (item),
		.failure_limit       (limit_q),
		.lockout_duration_ms (dur_q),
		.sts                 (sts),
		.result              (result)
	);

endmodule

// File: design/psalt_ctrl.sv
// Controller for the lockout table: sequences load, slot scan, resolve and execute.
// Depends on psalt_pkg.
module psalt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  psalt_pkg::dp_sts_t sts,
	output psalt_pkg::dp_cmd_t cmd,
	output logic              busy,
	output logic              done
);
	import psalt_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESOLVE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.scan_end) state_q <= ST_RESOLVE;
				end
				ST_RESOLVE: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd.load    = (state_q == ST_IDLE) && start;
		cmd.step    = (state_q == ST_SCAN);
		cmd.resolve = (state_q == ST_RESOLVE);
		cmd.exec    = (state_q == ST_EXEC);
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

// File: design/psalt_dp.sv
// Datapath for the lockout table: slot storage, serial key scan, entry update, result.
// Depends on psalt_pkg.
module psalt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  psalt_pkg::dp_cmd_t            cmd,
	input  psalt_pkg::item_t              item,
	input  logic [psalt_pkg::CNT_W-1:0]   failure_limit,
	input  logic [psalt_pkg::DUR_W-1:0]   lockout_duration_ms,
	output psalt_pkg::dp_sts_t            sts,
	output psalt_pkg::result_t            result
);
	import psalt_pkg::*;

	logic [KEY_W-1:0]  key_q  [SLOTS];
	logic [CNT_W-1:0]  fail_q [SLOTS];
	logic [TIME_W-1:0] lock_q [SLOTS];

	item_t             item_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  hit_q;
	logic [IDX_W-1:0]  free_q;
	logic              found_q;
	logic              have_free_q;

	logic [IDX_W-1:0]  sel_q;
	logic [KEY_W-1:0]  cur_key_q;
	logic [CNT_W-1:0]  cur_fail_q;
	logic [TIME_W-1:0] cur_lock_q;
	result_t           result_q;

	logic              scan_match;
	logic [IDX_W-1:0]  sel;
	logic              claim;
	logic              replace;
	logic [CNT_W-1:0]  fail_next;
	logic [TIME_W:0]   end_sum;
	logic [TIME_W-1:0] end_sat;
	logic              wr_en;
	logic [CNT_W-1:0]  wr_fail;
	logic [TIME_W-1:0] wr_lock;

	assign scan_match   = (key_q[idx_q] == item_q.peer_address);
	assign sts.scan_end = scan_match || (idx_q == IDX_W'(SLOTS - 1));

	always_comb begin
		if (found_q) begin
			sel = hit_q;
		end else if (have_free_q) begin
			sel = free_q;
		end else begin
			sel = item_q.peer_address[IDX_W-1:0];
		end
		claim   = (item_q.func == FUNC_CHECK) || (item_q.func == FUNC_FAIL);
		replace = claim && (key_q[sel] != item_q.peer_address);
	end

	always_comb begin
		fail_next = cur_fail_q + CNT_W'(1);
		end_sum   = {1'b0, item_q.now_ms} + (TIME_W + 1)'(lockout_duration_ms);
		end_sat   = end_sum[TIME_W] ? {TIME_W{1'b1}} : end_sum[TIME_W-1:0];
		wr_en     = 1'b0;
		wr_fail   = cur_fail_q;
		wr_lock   = cur_lock_q;
		case (item_q.func)
			FUNC_CHECK: begin
				wr_en = 1'b1;
			end
			FUNC_FAIL: begin
				wr_en   = 1'b1;
				wr_fail = fail_next;
				if (fail_next >= failure_limit) wr_lock = end_sat;
			end
			FUNC_OK: begin
				wr_en   = found_q;
				wr_fail = '0;
				wr_lock = '0;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				key_q[i]  <= '0;
				fail_q[i] <= '0;
				lock_q[i] <= '0;
			end
		end else if (cmd.exec && wr_en) begin
			key_q[sel_q]  <= cur_key_q;
			fail_q[sel_q] <= wr_fail;
			lock_q[sel_q] <= wr_lock;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			hit_q       <= '0;
			free_q      <= '0;
			found_q     <= 1'b0;
			have_free_q <= 1'b0;
		end else if (cmd.load) begin
			idx_q       <= '0;
			found_q     <= 1'b0;
			have_free_q <= 1'b0;
		end else if (cmd.step) begin
			idx_q <= idx_q + IDX_W'(1);
			if (scan_match) begin
				found_q <= 1'b1;
				hit_q   <= idx_q;
			end else if ((key_q[idx_q] == '0) && !have_free_q) begin
				have_free_q <= 1'b1;
				free_q      <= idx_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= item;
		if (cmd.resolve) begin
			sel_q <= sel;
			if (replace) begin
				cur_key_q  <= item_q.peer_address;
				cur_fail_q <= '0;
				cur_lock_q <= '0;
			end else begin
				cur_key_q  <= key_q[sel];
				cur_fail_q <= fail_q[sel];
				cur_lock_q <= lock_q[sel];
			end
		end
		if (cmd.exec) begin
			if ((item_q.func == FUNC_CHECK) && (cur_lock_q > item_q.now_ms)) begin
				result_q.locked            <= 1'b1;
				result_q.lock_remaining_ms <= cur_lock_q - item_q.now_ms;
			end else begin
				result_q.locked            <= 1'b0;
				result_q.lock_remaining_ms <= '0;
			end
		end
	end

	assign result = result_q;

endmodule

// File: design/psalt_checker.sv
// Port-level checker for the lockout table, bound to the top level.
// Depends on psalt_pkg and per_source_auth_lockout_table.
module psalt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input psalt_pkg::result_t result
);
	import psalt_pkg::*;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat longer than one cycle");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("result beat without a preceding item");

	a_unlocked_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.locked |-> result.lock_remaining_ms == '0)
		else $error("remaining time reported while unlocked");

	a_locked_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.locked |-> result.lock_remaining_ms != '0)
		else $error("locked with zero remaining time");

endmodule

bind per_source_auth_lockout_table psalt_checker u_psalt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
